// ===== rtl/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that prop holds at each clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that an antecedent implies a consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types, constants and SHA-256 helper functions.
// ----------------------------------------------------------------------------
package sks_pkg;
	localparam int IterW = 21;
	localparam logic [IterW-1:0] IterReset = 21'h100000;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] digest_t;
	typedef word_t [15:0] block_t;

	localparam digest_t Iv = '{32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	// block source selected by the controller
	typedef enum logic [1:0] {
		BLK_KEY  = 2'd0,
		BLK_MIX  = 2'd1,
		BLK_SALT = 2'd2
	} blk_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     load_in;   // capture key and salt
		logic     start;     // load schedule and working vars
		blk_sel_t sel;       // block being started
		logic     chain_iv;  // start from IV (else from chaining value)
		logic     round;     // perform one round
		logic     fin_init;  // fold into initial digest
		logic     fin_mid;   // fold into chaining value
		logic     fin_run;   // fold into running digest, bump counter
		logic     clr_run;   // clear running digest and counter
	} cmd_t;

	typedef struct packed {
		logic             last_round;
		logic [IterW-1:0] counter;
	} sts_t;

	function automatic word_t rotr(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t kconst(logic [5:0] i);
		word_t k [64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	// big-endian word from bytes 4*half..4*half+3 of a little-endian field
	function automatic word_t be_word(logic [63:0] f, logic half);
		logic [31:0] h;
		h = half ? f[63:32] : f[31:0];
		return {h[7:0], h[15:8], h[23:16], h[31:24]};
	endfunction

	// output word k: digest bytes 8k..8k+7, lowest byte in bits 7:0
	function automatic logic [63:0] pack_out(word_t a, word_t b);
		return {b[7:0], b[15:8], b[23:16], b[31:24], a[7:0], a[15:8], a[23:16], a[31:24]};
	endfunction
endpackage

// ===== rtl/sks_stream_if.sv =====
// ----------------------------------------------------------------------------
// sks_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface sks_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sks_ctrl.sv =====
// ----------------------------------------------------------------------------
// sks_ctrl
// Sequencer: key block, then per iteration a mix block and a salt block.
// ----------------------------------------------------------------------------
module sks_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  logic [sks_pkg::IterW-1:0] iter_count,
	input  sks_pkg::sts_t            sts,
	output sks_pkg::cmd_t            cmd
);
	import sks_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_KEY   = 6'b000010,
		S_CHECK = 6'b000100,
		S_MIX   = 6'b001000,
		S_SALT  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;   // rounds in progress inside current state

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_KEY;
				end
			end
			S_KEY: begin
				cmd.sel = BLK_KEY;
				if (!busy_q) begin
					cmd.start    = 1'b1;
					cmd.chain_iv = 1'b1;
				end else begin
					cmd.round = 1'b1;
					if (sts.last_round) begin
						cmd.fin_init = 1'b1;
						cmd.clr_run  = 1'b1;
						state_d      = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				// counter wraps to zero only after a full 21-bit run
				if (sts.counter >= iter_count) begin
					state_d = S_DONE;
				end else begin
					state_d = S_MIX;
				end
			end
			S_MIX: begin
				cmd.sel = BLK_MIX;
				if (!busy_q) begin
					cmd.start    = 1'b1;
					cmd.chain_iv = 1'b1;
				end else begin
					cmd.round = 1'b1;
					if (sts.last_round) begin
						cmd.fin_mid = 1'b1;
						state_d     = S_SALT;
					end
				end
			end
			S_SALT: begin
				cmd.sel = BLK_SALT;
				if (!busy_q) begin
					cmd.start = 1'b1;
				end else begin
					cmd.round = 1'b1;
					if (sts.last_round) begin
						cmd.fin_run = 1'b1;
						if (&sts.counter) begin
							state_d = S_DONE;
						end else begin
							state_d = S_CHECK;
						end
					end
				end
			end
			S_DONE: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (cmd.round && sts.last_round) begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/sks_datapath.sv =====
// ----------------------------------------------------------------------------
// sks_datapath
// One SHA-256 round per cycle while cmd.round is set, rolling 16-word schedule, digest registers.
// ----------------------------------------------------------------------------
module sks_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [63:0]   key_low,
	input  logic [63:0]   key_high,
	input  logic [63:0]   salt_low,
	input  logic [63:0]   salt_high,
	input  sks_pkg::cmd_t cmd,
	output sks_pkg::sts_t sts,
	output logic [63:0]   derived_word0,
	output logic [63:0]   derived_word1,
	output logic [63:0]   derived_word2,
	output logic [63:0]   derived_word3
);
	import sks_pkg::*;

	logic [63:0]      key_lo_q, key_hi_q, salt_lo_q, salt_hi_q;
	digest_t          init_q, run_q, mid_q, vars_q;
	block_t           w_q;
	logic [5:0]       rnd_q;
	logic [IterW-1:0] cnt_q;

	block_t  blk;
	digest_t base;
	word_t   wn, w_cur, t1, t2, s0, s1;
	digest_t vars_d;

	always_comb begin
		blk = '0;
		case (cmd.sel)
			BLK_KEY: begin
				blk[0]  = be_word(key_lo_q, 1'b0);
				blk[1]  = be_word(key_lo_q, 1'b1);
				blk[2]  = be_word(key_hi_q, 1'b0);
				blk[3]  = be_word(key_hi_q, 1'b1);
				blk[4]  = 32'h80000000;
				blk[15] = 32'd128;
			end
			BLK_MIX: begin
				for (int i = 0; i < 8; i++) begin
					blk[i]     = run_q[i];
					blk[8 + i] = init_q[i];
				end
			end
			BLK_SALT: begin
				blk[0]  = be_word(salt_lo_q, 1'b0);
				blk[1]  = be_word(salt_lo_q, 1'b1);
				blk[2]  = be_word(salt_hi_q, 1'b0);
				blk[3]  = be_word(salt_hi_q, 1'b1);
				blk[4]  = be_word({{(64-IterW){1'b0}}, cnt_q}, 1'b0);
				blk[5]  = be_word({{(64-IterW){1'b0}}, cnt_q}, 1'b1);
				blk[6]  = 32'h80000000;
				blk[15] = 32'd704;
			end
			default: begin
				blk = '0;
			end
		endcase
		base = cmd.chain_iv ? Iv : mid_q;
	end

	// w_q[0] is the word for the current round; window shifts each round
	always_comb begin
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn    = w_q[0] + s0 + w_q[9] + s1;
		w_cur = w_q[0];
		t1 = vars_q[7] + (rotr(vars_q[4], 6) ^ rotr(vars_q[4], 11) ^ rotr(vars_q[4], 25))
			+ ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6])) + kconst(rnd_q) + w_cur;
		t2 = (rotr(vars_q[0], 2) ^ rotr(vars_q[0], 13) ^ rotr(vars_q[0], 22))
			+ ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
		vars_d = {vars_q[6:4], vars_q[3] + t1, vars_q[2:0], t1 + t2};
	end

	assign sts.last_round = (&rnd_q);
	assign sts.counter    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q  <= '0;
			cnt_q  <= '0;
			init_q <= '0;
			run_q  <= '0;
		end else begin
			if (cmd.start) begin
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (cmd.fin_init) begin
				for (int i = 0; i < 8; i++) init_q[i] <= Iv[i] + vars_d[i];
			end
			if (cmd.clr_run) begin
				run_q <= '0;
				cnt_q <= '0;
			end else if (cmd.fin_run) begin
				for (int i = 0; i < 8; i++) run_q[i] <= mid_q[i] + vars_d[i];
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			key_lo_q  <= key_low;
			key_hi_q  <= key_high;
			salt_lo_q <= salt_low;
			salt_hi_q <= salt_high;
		end
		if (cmd.start) begin
			w_q    <= blk;
			vars_q <= base;
		end else if (cmd.round) begin
			w_q    <= {wn, w_q[15:1]};
			vars_q <= vars_d;
		end
		if (cmd.fin_mid) begin
			for (int i = 0; i < 8; i++) mid_q[i] <= Iv[i] + vars_d[i];
		end
	end

	assign derived_word0 = pack_out(run_q[0], run_q[1]);
	assign derived_word1 = pack_out(run_q[2], run_q[3]);
	assign derived_word2 = pack_out(run_q[4], run_q[5]);
	assign derived_word3 = pack_out(run_q[6], run_q[7]);
endmodule

// ===== rtl/sha256_key_stretch.sv =====
// Throughput: one transaction at a time; the single round unit runs one SHA-256
//   round per cycle while a block runs (load, then 64 rounds; 2 blocks per iteration).
// Reset: arst_n asynchronous, active low; clears controller, counter, initial and
//   running digests, and sets iteration_count to 1048576. No clearing pass.
// ----------------------------------------------------------------------------
// sha256_key_stretch
// Salted, iterated SHA-256 key stretching with a configurable iteration count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_key_stretch (
	input logic clk,
	input logic arst_n,
	sks_stream_if.sink   in_ch,
	sks_stream_if.source out_ch,
	sks_stream_if.sink   cfg_ch
);
	import sks_pkg::*;

	// iteration_count register; the user must write it only while idle, the block does not enforce this
	logic [IterW-1:0] iter_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= IterReset;
		end else if (cfg_ch.valid) begin
			iter_q <= cfg_ch.data;
		end
	end

	// controller: sequences key block, then mix/salt blocks per iteration
	sks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.iter_count(iter_q),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: round unit, schedule window, digest and counter registers
	sks_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_low      (in_ch.data.key_low),
		.key_high     (in_ch.data.key_high),
		.salt_low     (in_ch.data.salt_low),
		.salt_high    (in_ch.data.salt_high),
		.cmd          (cmd),
		.sts          (sts),
		.derived_word0(out_ch.data.derived_word0),
		.derived_word1(out_ch.data.derived_word1),
		.derived_word2(out_ch.data.derived_word2),
		.derived_word3(out_ch.data.derived_word3)
	);

	// no new transaction while a result is waiting
	`ASSERT_CLK(a_no_overlap, clk, arst_n, !(in_ch.ready && out_ch.valid), "ready with result pending")
	// accepted transaction leaves the idle state next cycle
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "accept not taken")
	// fold into running digest only on a last round
	`ASSERT_CLK(a_fin_last, clk, arst_n, !cmd.fin_run || sts.last_round, "fold before last round")
endmodule

// ===== test/sha256_key_stretch_tb.sv =====
// ----------------------------------------------------------------------------
// sha256_key_stretch_tb
// Sends key/salt requests under several iteration counts, predicts each
// stretched key with a behavioral SHA-256 and compares every result word.
// ----------------------------------------------------------------------------
module sha256_key_stretch_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sks_pkg::*;

	// request: key_low in bits 63:0, salt_high in bits 255:192
	typedef struct packed {
		logic [63:0] salt_high;
		logic [63:0] salt_low;
		logic [63:0] key_high;
		logic [63:0] key_low;
	} request_t;

	// derived key: derived_word0 in bits 63:0
	typedef struct packed {
		logic [63:0] derived_word3;
		logic [63:0] derived_word2;
		logic [63:0] derived_word1;
		logic [63:0] derived_word0;
	} derived_t;

	typedef logic [IterW-1:0] iters_t;
	typedef logic [7:0][31:0] hash_t;
	typedef logic [15:0][31:0] msg_blk_t;

	localparam int IdleLimit = 1000000;
	localparam int LastQuiet = 12;   // trailing requests with no idling

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bswap(logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// one SHA-256 compression, returns the updated chaining value
	function automatic hash_t sha_compress(hash_t h, msg_blk_t m);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
		hash_t r;
		for (int i = 0; i < 16; i++) w[i] = m[i];
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		{a, b, c, d, e, f, g, hh} = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
		for (int i = 0; i < 64; i++) begin
			t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ RoundK[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			hh = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		r = h;
		r[0] += a; r[1] += b; r[2] += c; r[3] += d;
		r[4] += e; r[5] += f; r[6] += g; r[7] += hh;
		return r;
	endfunction

	// expected derived keys in request order
	class stretch_scoreboard;
		derived_t pending[$];
		iters_t iterations = IterReset;

		function automatic derived_t stretch(request_t q);
			msg_blk_t m;
			hash_t init_d, run_d, h;
			derived_t o;
			// initial digest: SHA-256 of the bare 16-byte key
			m = '0;
			m[0] = bswap(q.key_low[31:0]);
			m[1] = bswap(q.key_low[63:32]);
			m[2] = bswap(q.key_high[31:0]);
			m[3] = bswap(q.key_high[63:32]);
			m[4] = 32'h80000000;
			m[15] = 32'd128;
			init_d = sha_compress(Iv, m);
			run_d = '0;
			for (int n = 0; n < int'(iterations); n++) begin
				for (int i = 0; i < 8; i++) begin
					m[i] = run_d[i];
					m[8+i] = init_d[i];
				end
				h = sha_compress(Iv, m);
				// second block: salt, 8-byte LE counter, padding, 704-bit length
				m = '0;
				m[0] = bswap(q.salt_low[31:0]);
				m[1] = bswap(q.salt_low[63:32]);
				m[2] = bswap(q.salt_high[31:0]);
				m[3] = bswap(q.salt_high[63:32]);
				m[4] = bswap(32'(n));
				m[6] = 32'h80000000;
				m[15] = 32'd704;
				run_d = sha_compress(h, m);
			end
			o.derived_word0 = {bswap(run_d[1]), bswap(run_d[0])};
			o.derived_word1 = {bswap(run_d[3]), bswap(run_d[2])};
			o.derived_word2 = {bswap(run_d[5]), bswap(run_d[4])};
			o.derived_word3 = {bswap(run_d[7]), bswap(run_d[6])};
			return o;
		endfunction

		function void note_request(request_t q);
			pending = {pending, stretch(q)};
		endfunction

		// appends one line per wrong word, or one for an unexpected result; nothing when all match
		function void check_result(derived_t got, ref string errs[$]);
			derived_t exp_d;
			if (pending.size() == 0) begin
				errs = {errs, $sformatf("unexpected result %h", got)};
				return;
			end
			exp_d = pending.pop_front();
			for (int k = 0; k < 4; k++)
				if (got[64*k +: 64] !== exp_d[64*k +: 64])
					errs = {errs, $sformatf("derived_word%0d got %h want %h",
						k, got[64*k +: 64], exp_d[64*k +: 64])};
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quiet = 1'b0;       // no idling on either side
	int errors = 0;
	int idle_cycles = 0;
	stretch_scoreboard sb = new();

	sks_stream_if #(.payload_t(request_t)) in_ch();
	sks_stream_if #(.payload_t(derived_t)) out_ch();
	sks_stream_if #(.payload_t(iters_t)) cfg_ch();

	sha256_key_stretch dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report(string s);
		$display("mismatch: %s", s);
		errors++;
	endtask

	// result side: random backpressure bursts, then check each transaction
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		string errs[$];
		if (out_ch.valid && out_ch.ready) begin
			errs.delete();
			sb.check_result(out_ch.data, errs);
			foreach (errs[i]) report(errs[i]);
		end
	end

	// watchdog: no transaction on any channel for too long ends the run
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// register write; only called with nothing in flight
	task automatic write_iterations(iters_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
		sb.iterations = v;
	endtask

	task automatic send_request(request_t q);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= q;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		sb.note_request(q);
	endtask

	// let the block drain before touching the register
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic request_t rand_request();
		request_t q;
		for (int i = 0; i < 8; i++) q[32*i +: 32] = $urandom();
		return q;
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		request_t q;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one iteration, field extremes and byte-order probes
		write_iterations(iters_t'(1));
		send_request('0);
		send_request('1);
		send_request({4{64'haaaaaaaa_aaaaaaaa}});
		send_request({4{64'h55555555_55555555}});
		send_request({64'h0, 64'h0, 64'h0, 64'h00000000_000000ff});
		send_request({64'h0, 64'h0, 64'hff000000_00000000, 64'h0});
		send_request({64'h0, 64'h00000000_000000ff, 64'h0, 64'h0});
		send_request({64'hff000000_00000000, 64'h0, 64'h0, 64'h0});
		send_request({64'h0, 64'h0, {2{64'hffffffff_ffffffff}}});
		send_request({{2{64'hffffffff_ffffffff}}, 64'h0, 64'h0});
		send_request({64'h0f0e0d0c_0b0a0908, 64'h07060504_03020100,
			64'h1f1e1d1c_1b1a1918, 64'h17161514_13121110});
		drain();

		// zero iterations: result is the cleared running digest
		write_iterations('0);
		send_request(rand_request());
		send_request('1);
		for (int i = 0; i < 6; i++) send_request(rand_request());
		drain();

		write_iterations(iters_t'(2));
		for (int i = 0; i < 25; i++) send_request(rand_request());
		drain();

		write_iterations(iters_t'(1));
		for (int i = 0; i < 20; i++) begin
			q = rand_request();
			// sparse or saturated fields now and then
			if ($urandom_range(0, 3) == 0) q.key_low = $urandom_range(0, 1) ? '0 : '1;
			if ($urandom_range(0, 3) == 0) q.salt_high = $urandom_range(0, 1) ? '0 : rand_word();
			send_request(q);
		end
		drain();

		write_iterations(iters_t'(3));
		for (int i = 0; i < 15; i++) send_request(rand_request());
		drain();

		// long stretch: counter bytes above the lowest one become nonzero
		write_iterations(iters_t'(2047));
		send_request(rand_request());
		drain();

		// final stretch with no idling on either side
		write_iterations(iters_t'($urandom_range(4, 7)));
		quiet <= 1'b1;
		for (int i = 0; i < LastQuiet; i++) send_request(rand_request());
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
